// ===== rtl/ptrr_pkg.sv =====
// Shared types and constants for the round-robin process table scheduler.
// No dependencies.
`default_nettype none
package ptrr_pkg;
    localparam int KIND_BITS = 3;
    localparam int TGT_BITS  = 17;

    typedef enum logic [2:0] {
        K_ADD  = 3'd0,
        K_FORK = 3'd1,
        K_TICK = 3'd2,
        K_TERM = 3'd3,
        K_WAIT = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        ST_READY    = 2'd0,
        ST_RUNNING  = 2'd1,
        ST_WAITING  = 2'd2,
        ST_FINISHED = 2'd3
    } t_run;

    typedef enum logic [1:0] {
        STS_OK   = 2'd0,
        STS_REJ  = 2'd1,
        STS_IDLE = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RDCUR,
        S_GOTCUR,
        S_TICK_SCAN,
        S_TICK_FIX,
        S_FIND,
        S_TERM_PAR,
        S_WALL,
        S_WAIT_FIN,
        S_RDOUT,
        S_OUT
    } t_state;
endpackage
`default_nettype wire

// ===== rtl/ptrr_if.sv =====
// Valid/ready channel interface carrying a payload.
// Depends on nothing.
`default_nettype none
interface ptrr_if #(
    parameter int W = 8
);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/ptrr_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none
module ptrr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire [WIDTH-1:0]          i_wdata,
    input  wire [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/process_table_round_robin_scheduler_unit.sv =====
// Round-robin process table scheduler: top level with control sequencer.
// Depends on ptrr_pkg, ptrr_if and ptrr_ram.
// Add and fork need no scan; tick, terminate and wait may scan the used slots, one slot
// read per cycle through the single read port.
// One item is in work at a time; the next item is taken once the sequencer is back in idle
// and the output register is empty or being read in that cycle.
// Synchronous active-low reset clears the sequencer, used count, current task, pid
// counter and output valid; slot memory is not cleared, only used slots are read.
`default_nettype none
module process_table_round_robin_scheduler_unit #(
    parameter int SLOTS    = 16,
    parameter int PID_BITS = 16
) (
    input  wire i_clk,
    input  wire i_rst_n,
    ptrr_if.sink   i_in,
    ptrr_if.source o_out
);
    localparam int SB = $clog2(SLOTS);
    localparam int CB = $clog2(SLOTS + 1);
    localparam int MW = 2 * PID_BITS + 2 + 5 + 1;
    localparam int OW = 2 + 16 + 4 + 1;

    // memory entry: pid, parent, run, awaited, parent waiting
    typedef struct packed {
        logic [PID_BITS-1:0] pid;
        logic [PID_BITS-1:0] par;
        logic [1:0]          run;
        logic [4:0]          aw;
        logic                pw;
    } t_ent;

    ptrr_pkg::t_state r_st, n_st;
    logic [CB-1:0]       r_used;
    logic [SB-1:0]       r_cur;
    logic                r_cv;
    logic [PID_BITS-1:0] r_nfp;
    logic [2:0]          r_kind;
    logic [16:0]         r_tgt;
    logic [CB-1:0]       r_k;
    logic [SB-1:0]       r_idx;
    logic                r_rdv;
    logic [SB-1:0]       r_ridx;
    t_ent                r_ce;
    logic [5:0]          r_cnt;
    logic [1:0]          r_sts;
    logic [PID_BITS-1:0] r_rpid;
    logic                r_gave;
    logic                r_ovalid;
    logic [OW-1:0]       r_odata;

    logic          we;
    logic [SB-1:0] waddr, raddr;
    t_ent          wdat, rdat;
    logic [MW-1:0] rraw;

    ptrr_ram #(.WIDTH(MW), .DEPTH(SLOTS)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdat),
        .i_raddr(raddr),
        .o_rdata(rraw)
    );
    assign rdat = t_ent'(rraw);

    logic full;
    assign full  = (r_used >= CB'(SLOTS));
    assign i_in.ready = (r_st == ptrr_pkg::S_IDLE) && !(r_ovalid && !o_out.ready);
    assign o_out.valid = r_ovalid;
    assign o_out.data  = r_odata;

    // scan index wrap helper
    function automatic logic [SB-1:0] wrapinc(input logic [SB-1:0] a, input logic [CB-1:0] n);
        logic [CB:0] s;
        begin
            s = {1'b0, CB'(a)} + 1'b1;
            if (s >= {1'b0, n}) s = '0;
            wrapinc = s[SB-1:0];
        end
    endfunction

    // next state and datapath control
    always_comb begin
        n_st  = r_st;
        we    = 1'b0;
        waddr = r_cur;
        wdat  = r_ce;
        raddr = r_idx;
        unique case (r_st)
            ptrr_pkg::S_IDLE:      raddr = r_cur;
            ptrr_pkg::S_RDCUR:     raddr = r_cur;
            ptrr_pkg::S_RDOUT:     raddr = r_cur;
            ptrr_pkg::S_OUT:       raddr = r_cur;
            default:               raddr = r_idx;
        endcase
        if (r_st == ptrr_pkg::S_IDLE && i_in.valid && i_in.ready) begin
            n_st = ptrr_pkg::S_RDCUR;
        end
        unique case (r_st)
            ptrr_pkg::S_IDLE: ;
            ptrr_pkg::S_RDCUR: n_st = ptrr_pkg::S_GOTCUR;
            ptrr_pkg::S_GOTCUR: begin
                n_st = ptrr_pkg::S_RDOUT;
                unique case (r_kind)
                    ptrr_pkg::K_ADD, ptrr_pkg::K_FORK: begin
                        if (!full && (r_kind == ptrr_pkg::K_ADD || r_cv)) begin
                            we         = 1'b1;
                            waddr      = r_used[SB-1:0];
                            wdat.pid   = r_nfp;
                            wdat.par   = (r_kind == ptrr_pkg::K_ADD) ? '0 : rdat.pid;
                            wdat.run   = ptrr_pkg::ST_READY;
                            wdat.aw    = '0;
                            wdat.pw    = 1'b0;
                        end
                    end
                    ptrr_pkg::K_TICK: begin
                        if (r_used != '0) n_st = ptrr_pkg::S_TICK_SCAN;
                    end
                    ptrr_pkg::K_TERM: begin
                        if (r_cv) begin
                            we       = 1'b1;
                            wdat     = rdat;
                            wdat.run = ptrr_pkg::ST_FINISHED;
                            if (rdat.pw) n_st = ptrr_pkg::S_FIND;
                        end
                    end
                    ptrr_pkg::K_WAIT: begin
                        if (r_cv && 17'(rdat.pid) != r_tgt && r_tgt != '0) begin
                            if (r_tgt == '1) n_st = ptrr_pkg::S_WALL;
                            else             n_st = ptrr_pkg::S_FIND;
                        end
                    end
                    default: ;
                endcase
            end
            ptrr_pkg::S_TICK_SCAN: begin
                if (r_rdv && (rdat.run == ptrr_pkg::ST_READY
                              || rdat.run == ptrr_pkg::ST_RUNNING)) begin
                    we       = 1'b1;
                    waddr    = r_ridx;
                    wdat     = rdat;
                    wdat.run = ptrr_pkg::ST_RUNNING;
                    n_st     = ptrr_pkg::S_TICK_FIX;
                end else if (r_rdv && r_k == r_used) begin
                    n_st = ptrr_pkg::S_RDOUT;
                end
            end
            ptrr_pkg::S_TICK_FIX: begin
                // demote old current: r_ce holds it, write only if running and different
                if (r_cv && r_ce.run == ptrr_pkg::ST_RUNNING && r_cur != r_ridx) begin
                    we       = 1'b1;
                    waddr    = r_cur;
                    wdat     = r_ce;
                    wdat.run = ptrr_pkg::ST_READY;
                end
                n_st = ptrr_pkg::S_RDOUT;
            end
            ptrr_pkg::S_FIND: begin
                // lookup pid: for terminate the parent, for wait the target
                if (r_rdv && ((r_kind == ptrr_pkg::K_TERM) ? (rdat.pid == r_ce.par)
                              : (17'(rdat.pid) == r_tgt))) begin
                    we    = 1'b1;
                    waddr = r_ridx;
                    wdat  = rdat;
                    if (r_kind == ptrr_pkg::K_TERM) begin
                        if (rdat.aw != '0) wdat.aw = rdat.aw - 1'b1;
                        if (rdat.aw <= 5'd1) wdat.run = ptrr_pkg::ST_READY;
                        n_st = ptrr_pkg::S_RDOUT;
                    end else if (rdat.run == ptrr_pkg::ST_FINISHED) begin
                        we   = 1'b0;
                        n_st = ptrr_pkg::S_RDOUT;
                    end else begin
                        wdat.pw = 1'b1;
                        n_st    = ptrr_pkg::S_WAIT_FIN;
                    end
                end else if (r_rdv && r_k == r_used) begin
                    n_st = ptrr_pkg::S_RDOUT;
                end
            end
            ptrr_pkg::S_WALL: begin
                if (r_rdv && rdat.par == r_ce.pid && rdat.par != rdat.pid
                    && rdat.run != ptrr_pkg::ST_FINISHED) begin
                    we      = 1'b1;
                    waddr   = r_ridx;
                    wdat    = rdat;
                    wdat.pw = 1'b1;
                end
                if (r_rdv && r_k == r_used) n_st = ptrr_pkg::S_WAIT_FIN;
            end
            ptrr_pkg::S_WAIT_FIN: begin
                we      = 1'b1;
                waddr   = r_cur;
                wdat    = r_ce;
                if (r_tgt == '1) begin
                    wdat.aw = (r_cnt > 6'd31) ? 5'd31 : r_cnt[4:0];
                    if (r_cnt != '0) wdat.run = ptrr_pkg::ST_WAITING;
                end else begin
                    wdat.aw  = 5'd1;
                    wdat.run = ptrr_pkg::ST_WAITING;
                end
                n_st = ptrr_pkg::S_RDOUT;
            end
            ptrr_pkg::S_RDOUT: n_st = ptrr_pkg::S_OUT;
            ptrr_pkg::S_OUT: begin
                if (!r_ovalid || o_out.ready) n_st = ptrr_pkg::S_IDLE;
            end
            default: n_st = ptrr_pkg::S_IDLE;
        endcase
    end

    logic [PID_BITS-1:0] opid;
    assign opid = r_gave ? r_rpid : (r_cv ? rdat.pid : '0);

    // sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= ptrr_pkg::S_IDLE;
            r_used   <= '0;
            r_cur    <= '0;
            r_cv     <= 1'b0;
            r_nfp    <= '0;
            r_ovalid <= 1'b0;
            r_rdv    <= 1'b0;
        end else begin
            r_st <= n_st;
            if (r_ovalid && o_out.ready && r_st != ptrr_pkg::S_OUT) r_ovalid <= 1'b0;
            unique case (r_st)
                ptrr_pkg::S_IDLE: begin
                    if (i_in.valid && i_in.ready) begin
                        r_kind <= i_in.data[2:0];
                        r_tgt  <= i_in.data[19:3];
                        r_gave <= 1'b0;
                        r_sts  <= ptrr_pkg::STS_REJ;
                        r_cnt  <= '0;
                    end
                end
                ptrr_pkg::S_RDCUR: ;
                ptrr_pkg::S_GOTCUR: begin
                    r_ce  <= rdat;
                    r_k   <= '0;
                    r_rdv <= 1'b0;
                    r_idx <= (r_kind == ptrr_pkg::K_TICK && r_cv) ? wrapinc(r_cur, r_used)
                                                                 : '0;
                    unique case (r_kind)
                        ptrr_pkg::K_ADD, ptrr_pkg::K_FORK: begin
                            if (!full && (r_kind == ptrr_pkg::K_ADD || r_cv)) begin
                                r_sts  <= ptrr_pkg::STS_OK;
                                r_gave <= 1'b1;
                                r_rpid <= r_nfp;
                                r_nfp  <= r_nfp + 1'b1;
                                r_used <= r_used + 1'b1;
                            end
                        end
                        ptrr_pkg::K_TICK: begin
                            r_sts <= ptrr_pkg::STS_IDLE;
                        end
                        ptrr_pkg::K_TERM: if (r_cv) r_sts <= ptrr_pkg::STS_OK;
                        default: ;
                    endcase
                end
                ptrr_pkg::S_TICK_SCAN, ptrr_pkg::S_FIND, ptrr_pkg::S_WALL: begin
                    // one slot per cycle: issue read, check the data in the next cycle; hold on exit
                    if ((!r_rdv || r_k != r_used) && n_st == r_st) begin
                        r_ridx <= r_idx;
                        r_rdv  <= 1'b1;
                        r_k    <= r_k + 1'b1;
                        r_idx  <= (r_st == ptrr_pkg::S_TICK_SCAN) ? wrapinc(r_idx, r_used)
                                                                 : r_idx + 1'b1;
                    end
                    if (r_st == ptrr_pkg::S_TICK_SCAN && n_st == ptrr_pkg::S_TICK_FIX) begin
                        r_sts <= ptrr_pkg::STS_OK;
                    end
                    if (r_st == ptrr_pkg::S_WALL && we) r_cnt <= r_cnt + 1'b1;
                    if (r_st == ptrr_pkg::S_FIND && r_kind == ptrr_pkg::K_WAIT
                        && n_st == ptrr_pkg::S_WAIT_FIN) r_sts <= ptrr_pkg::STS_OK;
                    if (r_st == ptrr_pkg::S_WALL && n_st == ptrr_pkg::S_WAIT_FIN
                        && (r_cnt != '0 || we)) r_sts <= ptrr_pkg::STS_OK;
                end
                ptrr_pkg::S_TICK_FIX: begin
                    r_cur <= r_ridx;
                    r_cv  <= 1'b1;
                end
                ptrr_pkg::S_WAIT_FIN: ;
                ptrr_pkg::S_RDOUT: ;
                ptrr_pkg::S_OUT: begin
                    if (!r_ovalid || o_out.ready) begin
                        r_ovalid <= 1'b1;
                        r_odata  <= {r_sts, 16'(opid), r_cv ? 4'(r_cur) : 4'd0, r_cv};
                    end
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== tb/tb_process_table_round_robin_scheduler_unit.sv =====
// Self-checking testbench for the round-robin process table scheduler.
// Depends on ptrr_pkg, ptrr_if and the top level process_table_round_robin_scheduler_unit.
`timescale 1ns / 1ps
`default_nettype none
module tb_process_table_round_robin_scheduler_unit;

    localparam int SLOTS     = 16;
    localparam int PID_BITS  = 16;
    localparam int IN_W      = ptrr_pkg::KIND_BITS + ptrr_pkg::TGT_BITS;
    localparam int OUT_W     = 2 + PID_BITS + 4 + 1;
    localparam int N_RANDOM  = 1630;
    localparam int LIMIT     = 600000;
    localparam logic [16:0] TGT_ALL = 17'h1FFFF;

    typedef struct packed {
        logic [1:0]          status;
        logic [PID_BITS-1:0] pid;
        logic [3:0]          slot;
        logic                valid;
    } t_sched_res;

    typedef struct {
        logic [2:0]  kind;
        logic [16:0] tgt;
        bit          typed;
        t_sched_res  res;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;
    int   cycles;
    int   fails;

    ptrr_if #(.W(IN_W))  in_ch ();
    ptrr_if #(.W(OUT_W)) out_ch ();

    process_table_round_robin_scheduler_unit #(
        .SLOTS    (SLOTS),
        .PID_BITS (PID_BITS)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    // Shadow copy of the process table
    logic [PID_BITS-1:0] tbl_pid     [SLOTS];
    logic [PID_BITS-1:0] tbl_parent  [SLOTS];
    ptrr_pkg::t_run      tbl_run     [SLOTS];
    int                  tbl_awaited [SLOTS];
    bit                  tbl_pwait   [SLOTS];
    int                  tbl_used;
    int                  cur_slot;
    bit                  cur_valid;
    logic [PID_BITS-1:0] free_pid;

    t_sched_res pending_res[$];
    int         kind_seen  [8];
    int         status_seen[4];

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // Lowest used slot holding the pid, SLOTS when absent
    function automatic int lookup_pid(input longint pid);
        for (int i = 0; i < tbl_used; i++) begin
            if (longint'(tbl_pid[i]) == pid) return i;
        end
        return SLOTS;
    endfunction

    function automatic bit place_task(input logic [PID_BITS-1:0] parent,
                                      output logic [PID_BITS-1:0] pid);
        pid = '0;
        if (tbl_used >= SLOTS) return 1'b0;
        tbl_pid[tbl_used]     = free_pid;
        tbl_parent[tbl_used]  = parent;
        tbl_run[tbl_used]     = ptrr_pkg::ST_READY;
        tbl_awaited[tbl_used] = 0;
        tbl_pwait[tbl_used]   = 1'b0;
        pid                   = free_pid;
        free_pid              = free_pid + 1'b1;
        tbl_used++;
        return 1'b1;
    endfunction

    function automatic logic [1:0] tick_next();
        int start;
        int idx;
        if (tbl_used == 0) return ptrr_pkg::STS_IDLE;
        start = cur_valid ? (cur_slot + 1) % tbl_used : 0;
        for (int k = 0; k < tbl_used; k++) begin
            idx = (start + k) % tbl_used;
            if (tbl_run[idx] == ptrr_pkg::ST_READY || tbl_run[idx] == ptrr_pkg::ST_RUNNING) begin
                if (cur_valid && tbl_run[cur_slot] == ptrr_pkg::ST_RUNNING)
                    tbl_run[cur_slot] = ptrr_pkg::ST_READY;
                cur_slot           = idx;
                cur_valid          = 1'b1;
                tbl_run[idx]       = ptrr_pkg::ST_RUNNING;
                return ptrr_pkg::STS_OK;
            end
        end
        return ptrr_pkg::STS_IDLE;
    endfunction

    function automatic void end_current();
        int p;
        tbl_run[cur_slot] = ptrr_pkg::ST_FINISHED;
        if (!tbl_pwait[cur_slot]) return;
        p = lookup_pid(longint'(tbl_parent[cur_slot]));
        if (p >= SLOTS) return;
        if (tbl_awaited[p] > 0) tbl_awaited[p]--;
        if (tbl_awaited[p] == 0) tbl_run[p] = ptrr_pkg::ST_READY;
    endfunction

    function automatic logic [1:0] block_current(input longint tgt);
        logic [PID_BITS-1:0] me;
        int cnt;
        int t;
        me  = tbl_pid[cur_slot];
        cnt = 0;
        if (longint'(me) == tgt || tgt == 0) return ptrr_pkg::STS_REJ;
        if (tgt == -1) begin
            for (int i = 0; i < tbl_used; i++) begin
                if (tbl_parent[i] == me && tbl_parent[i] != tbl_pid[i]
                        && tbl_run[i] != ptrr_pkg::ST_FINISHED) begin
                    tbl_pwait[i] = 1'b1;
                    cnt++;
                end
            end
            tbl_awaited[cur_slot] = (cnt > 31) ? 31 : cnt;
            if (cnt == 0) return ptrr_pkg::STS_REJ;
        end else begin
            t = lookup_pid(tgt);
            if (t >= SLOTS || tbl_run[t] == ptrr_pkg::ST_FINISHED) return ptrr_pkg::STS_REJ;
            tbl_awaited[cur_slot] = 1;
            tbl_pwait[t]          = 1'b1;
        end
        tbl_run[cur_slot] = ptrr_pkg::ST_WAITING;
        return ptrr_pkg::STS_OK;
    endfunction

    // Advance the shadow table by one item and return its result
    function automatic t_sched_res schedule_step(input logic [2:0] kind,
                                                 input logic [16:0] tgt_raw);
        t_sched_res r;
        logic [PID_BITS-1:0] npid;
        bit gave;
        longint tgt;
        tgt  = longint'($signed(tgt_raw));
        gave = 1'b0;
        r.status = ptrr_pkg::STS_REJ;
        case (kind)
            ptrr_pkg::K_ADD: begin
                if (place_task('0, npid)) begin
                    r.status = ptrr_pkg::STS_OK;
                    gave = 1'b1;
                end
            end
            ptrr_pkg::K_FORK: begin
                if (cur_valid && place_task(tbl_pid[cur_slot], npid)) begin
                    r.status = ptrr_pkg::STS_OK;
                    gave = 1'b1;
                end
            end
            ptrr_pkg::K_TICK: r.status = tick_next();
            ptrr_pkg::K_TERM: begin
                if (cur_valid) begin
                    end_current();
                    r.status = ptrr_pkg::STS_OK;
                end
            end
            ptrr_pkg::K_WAIT: if (cur_valid) r.status = block_current(tgt);
            default: r.status = ptrr_pkg::STS_REJ;
        endcase
        r.pid   = gave ? npid : (cur_valid ? tbl_pid[cur_slot] : '0);
        r.slot  = cur_valid ? 4'(cur_slot) : 4'd0;
        r.valid = cur_valid;
        return r;
    endfunction

    // Receiver stall pattern: stretches of full rate, then random stalls
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if ((cycles / 500) % 3 == 0) begin
            out_ch.ready <= 1'b1;
        end else begin
            out_ch.ready <= ($urandom_range(0, 9) < 6);
        end
    end

    // Compare each result item with the oldest expectation
    always @(posedge i_clk) begin
        t_sched_res got;
        t_sched_res exp;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = out_ch.data;
            if (pending_res.size() == 0) begin
                $error("unexpected result item %h", got);
                fails++;
            end else begin
                exp = pending_res.pop_front();
                status_seen[got.status]++;
                if (got.status !== exp.status) begin
                    $error("status exp %0d got %0d", exp.status, got.status);
                    fails++;
                end
                if (got.pid !== exp.pid) begin
                    $error("result_pid exp %0d got %0d", exp.pid, got.pid);
                    fails++;
                end
                if (got.slot !== exp.slot) begin
                    $error("running_slot exp %0d got %0d", exp.slot, got.slot);
                    fails++;
                end
                if (got.valid !== exp.valid) begin
                    $error("running_valid exp %0d got %0d", exp.valid, got.valid);
                    fails++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("Regression FAIL");
            $finish;
        end
    end

    // Hold the item until accepted; the caller decides the next drive
    task automatic push_item(input logic [2:0] kind, input logic [16:0] tgt,
                             input bit typed, input t_sched_res res);
        t_sched_res pred;
        in_ch.valid <= 1'b1;
        in_ch.data  <= {tgt, kind};
        do @(posedge i_clk); while (!in_ch.ready);
        pred = schedule_step(kind, tgt);
        pending_res.push_back(typed ? res : pred);
        kind_seen[kind]++;
    endtask

    function automatic logic [16:0] pick_target();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35) return TGT_ALL;
        if (r < 80) return 17'($urandom_range(0, tbl_used + 1));
        if (r < 95) return 17'($urandom_range(0, 65535));
        return 17'd65535;
    endfunction

    function automatic logic [2:0] pick_kind();
        int r;
        r = $urandom_range(0, 999);
        if (r < 12) return ptrr_pkg::K_ADD;
        if (r < 24) return ptrr_pkg::K_FORK;
        if (r < 80) return ptrr_pkg::K_TERM;
        if (r < 110) return 3'($urandom_range(5, 7));
        if (r < 450) return ptrr_pkg::K_WAIT;
        return ptrr_pkg::K_TICK;
    endfunction

    t_dir_row dir_rows[] = '{
        '{ptrr_pkg::K_TICK, 17'd0,     1'b1, '{ptrr_pkg::STS_IDLE, 16'd0, 4'd0, 1'b0}},
        '{ptrr_pkg::K_FORK, 17'd0,     1'b1, '{ptrr_pkg::STS_REJ,  16'd0, 4'd0, 1'b0}},
        '{ptrr_pkg::K_TERM, 17'd0,     1'b1, '{ptrr_pkg::STS_REJ,  16'd0, 4'd0, 1'b0}},
        '{ptrr_pkg::K_WAIT, TGT_ALL,   1'b1, '{ptrr_pkg::STS_REJ,  16'd0, 4'd0, 1'b0}},
        '{3'd5,             17'd0,     1'b1, '{ptrr_pkg::STS_REJ,  16'd0, 4'd0, 1'b0}},
        '{3'd7,             TGT_ALL,   1'b1, '{ptrr_pkg::STS_REJ,  16'd0, 4'd0, 1'b0}},
        '{ptrr_pkg::K_ADD,  17'd0,     1'b1, '{ptrr_pkg::STS_OK,   16'd0, 4'd0, 1'b0}},
        '{ptrr_pkg::K_TICK, 17'd0,     1'b1, '{ptrr_pkg::STS_OK,   16'd0, 4'd0, 1'b1}},
        '{ptrr_pkg::K_WAIT, 17'd0,     1'b1, '{ptrr_pkg::STS_REJ,  16'd0, 4'd0, 1'b1}},
        '{ptrr_pkg::K_WAIT, TGT_ALL,   1'b1, '{ptrr_pkg::STS_REJ,  16'd0, 4'd0, 1'b1}},
        '{ptrr_pkg::K_FORK, 17'd0,     1'b1, '{ptrr_pkg::STS_OK,   16'd1, 4'd0, 1'b1}},
        '{ptrr_pkg::K_WAIT, 17'd65535, 1'b1, '{ptrr_pkg::STS_REJ,  16'd0, 4'd0, 1'b1}},
        '{3'd6,             17'd1,     1'b1, '{ptrr_pkg::STS_REJ,  16'd0, 4'd0, 1'b1}},
        '{ptrr_pkg::K_WAIT, TGT_ALL,   1'b0, '0},
        '{ptrr_pkg::K_TICK, 17'd0,     1'b0, '0},
        '{ptrr_pkg::K_FORK, 17'd0,     1'b0, '0},
        '{ptrr_pkg::K_WAIT, 17'd2,     1'b0, '0},
        '{ptrr_pkg::K_TICK, 17'd0,     1'b0, '0},
        '{ptrr_pkg::K_TERM, 17'd0,     1'b0, '0},
        '{ptrr_pkg::K_WAIT, 17'd1,     1'b0, '0},
        '{ptrr_pkg::K_TERM, 17'd0,     1'b0, '0},
        '{ptrr_pkg::K_TICK, 17'd0,     1'b0, '0},
        '{ptrr_pkg::K_TICK, 17'd0,     1'b0, '0},
        '{ptrr_pkg::K_WAIT, 17'd2,     1'b0, '0}
    };

    initial begin
        int burst;
        int drain;
        fails        = 0;
        cycles       = 0;
        tbl_used     = 0;
        cur_slot     = 0;
        cur_valid    = 1'b0;
        free_pid     = '0;
        for (int i = 0; i < SLOTS; i++) begin
            tbl_pid[i]     = '0;
            tbl_parent[i]  = '0;
            tbl_run[i]     = ptrr_pkg::ST_FINISHED;
            tbl_awaited[i] = 0;
            tbl_pwait[i]   = 1'b0;
        end
        i_rst_n     = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data  = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows, back to back
        foreach (dir_rows[i])
            push_item(dir_rows[i].kind, dir_rows[i].tgt, dir_rows[i].typed, dir_rows[i].res);
        in_ch.valid <= 1'b0;

        // Random bursts with random gaps; one full drain halfway
        burst = 0;
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM / 2) begin
                in_ch.valid <= 1'b0;
                wait (pending_res.size() == 0);
                @(posedge i_clk);
            end
            if (burst == 0) begin
                in_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
                burst = $urandom_range(1, 24);
            end
            push_item(pick_kind(), pick_target(), 1'b0, '0);
            burst--;
        end
        in_ch.valid <= 1'b0;

        // Drain with a bound, then let the block settle
        drain = 0;
        while (pending_res.size() != 0 && drain < 20000) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (60) @(posedge i_clk);

        $display("covered: add %0d fork %0d tick %0d term %0d wait %0d bad kind %0d",
                 kind_seen[ptrr_pkg::K_ADD], kind_seen[ptrr_pkg::K_FORK],
                 kind_seen[ptrr_pkg::K_TICK], kind_seen[ptrr_pkg::K_TERM],
                 kind_seen[ptrr_pkg::K_WAIT],
                 kind_seen[5] + kind_seen[6] + kind_seen[7]);
        $display("results: ok %0d rejected %0d idle %0d, slots used %0d",
                 status_seen[ptrr_pkg::STS_OK], status_seen[ptrr_pkg::STS_REJ],
                 status_seen[ptrr_pkg::STS_IDLE], tbl_used);
        if (fails == 0 && pending_res.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== files.f =====
rtl/ptrr_pkg.sv
rtl/ptrr_if.sv
rtl/ptrr_ram.sv
rtl/process_table_round_robin_scheduler_unit.sv
tb/tb_process_table_round_robin_scheduler_unit.sv
